// ===== src/stq_pkg.sv =====
// Package for the sorted timer queue: status codes, operation codes and the
// word types shared by the queue and its testbench. No dependencies.
package stq_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;

    localparam int MAX_FIRE = 16;

    typedef struct packed {
        logic [15:0] owner;
        logic [15:0] callback;
        logic [31:0] argument;
        logic        kind;
    } t_payload;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  handle;
        t_payload    fired;
        logic        last;
    } t_result;

endpackage

// ===== src/stq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/sorted_timer_queue.sv =====
// Sorted timer queue: a timer list kept in due-step order, with add, cancel
// and tick operations. Uses stq_pkg and stq_ram.
//
// A timer is added with a delay in steps and receives the lowest free slot as
// its handle. An entry due no later than the head goes first; otherwise one
// due no earlier than the tail goes last; otherwise it goes just before the
// first entry due at or after it. A cancel word removes a timer by handle. A
// tick word advances the step counter by one and emits each timer that is now
// due, head first, with last marking the final one; a tick with nothing due
// gives no word, and at most sixteen timers fire per tick. Operation code 3 is
// ignored. The block handles one input word at a time and holds o_stall high
// until that word is finished. An add reads due steps from a RAM through the
// shared compare unit: the head first, then the tail, then the order list
// from position one onward; the insert itself is a single parallel shift of
// the order list. A cancel searches the order list one entry per cycle and
// closes the gap in one parallel shift. A tick takes each fired timer through
// five steps (check, read, wait, hold, remove). Every result passes through
// one output register; while it is occupied and i_stall is high, the
// sequencer waits.
module sorted_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_delay_steps,
    input  logic [15:0] i_owner_id,
    input  logic [15:0] i_callback_id,
    input  logic [31:0] i_argument,
    input  logic        i_script_kind,
    input  logic [3:0]  i_cancel_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_handle,
    output logic [15:0] o_fired_owner,
    output logic [15:0] o_fired_callback,
    output logic [31:0] o_fired_argument,
    output logic        o_fired_kind,
    output logic        o_last
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $bits(stq_pkg::t_payload);

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_SHIFT, S_CAN_SRCH, S_REMOVE,
        S_TICK_CHK, S_TICK_RD, S_TICK_WAIT, S_TICK_OUT, S_PUT
    } t_state;

    t_state r_state;
    logic [31:0]   r_step;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_order [QUEUE_DEPTH];
    logic [CW-1:0] r_pos;
    logic [AW-1:0] r_slot;
    logic [31:0]   r_due;
    logic [4:0]    r_fired;
    logic          r_after_tick;
    logic          r_tail_chk;
    stq_pkg::t_result r_res;
    logic          r_ovalid;
    stq_pkg::t_result r_out;

    // Free slot search: lowest slot not in the order list.
    logic [QUEUE_DEPTH-1:0] used;
    logic [AW-1:0]          free_slot;
    always_comb begin
        used = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (CW'(i) < r_count) begin
                used[r_order[i]] = 1'b1;
            end
        end
        free_slot = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!used[i]) begin
                free_slot = AW'(i);
            end
        end
    end

    // RAM ports, shared by all operations.
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   due_rd;
    stq_pkg::t_payload pay_rd, pay_wr;
    logic [AW-1:0] pos_idx;
    assign pos_idx = r_pos[AW-1:0];

    assign pay_wr = '{owner: i_owner_id, callback: i_callback_id,
                      argument: i_argument, kind: i_script_kind};
    assign ram_we = (r_state == S_IDLE) && i_valid && (i_func == stq_pkg::FUNC_ADD)
                    && (r_count < CW'(QUEUE_DEPTH));

    // A tick always works on the head entry, and its read data must stay put
    // while the fired word waits for the output register.
    always_comb begin
        ram_raddr = r_order[pos_idx];
        if (r_state == S_TICK_CHK || r_state == S_TICK_RD ||
            r_state == S_TICK_WAIT || r_state == S_TICK_OUT) begin
            ram_raddr = r_order[0];
        end
    end

    stq_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_due (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(free_slot),
        .i_wdata(r_step + 32'(i_delay_steps)), .i_raddr(ram_raddr), .o_rdata(due_rd)
    );
    stq_ram #(.WIDTH(PW), .DEPTH(QUEUE_DEPTH)) u_pay (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(free_slot),
        .i_wdata(pay_wr), .i_raddr(ram_raddr), .o_rdata(pay_rd)
    );

    // The shared compare unit: new due step against the stored one.
    logic due_le;
    logic due_ge;
    assign due_le = (due_rd <= r_due);
    assign due_ge = (r_due <= due_rd);

    logic out_free;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall = (r_state != S_IDLE);

    // Output register load: the held fired word at the end of a tick (with
    // last set), a held fired word once the next one is due, or a single result.
    logic             out_load;
    stq_pkg::t_result out_word;
    always_comb begin
        out_load = 1'b0;
        out_word = r_res;
        case (r_state)
            S_TICK_CHK: begin
                if ((r_count == '0 || r_fired == 5'(stq_pkg::MAX_FIRE)) &&
                    r_fired != '0 && out_free) begin
                    out_load = 1'b1;
                    out_word.last = 1'b1;
                end
            end
            S_TICK_OUT: out_load = (r_fired != '0) && out_free;
            S_PUT:      out_load = out_free;
            default:    out_load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_fired  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= out_load || (r_ovalid && i_stall);
            if (out_load) begin
                r_out <= out_word;
            end
            case (r_state)
                S_IDLE: begin
                    r_after_tick <= 1'b0;
                    if (i_valid) begin
                        case (i_func)
                            stq_pkg::FUNC_ADD: begin
                                if (r_count >= CW'(QUEUE_DEPTH)) begin
                                    r_res <= '{status: stq_pkg::ST_FULL, handle: '0,
                                               fired: '0, last: 1'b1};
                                    r_state <= S_PUT;
                                end else begin
                                    r_slot <= free_slot;
                                    r_due  <= r_step + 32'(i_delay_steps);
                                    r_pos  <= '0;
                                    r_tail_chk <= 1'b0;
                                    r_state <= (r_count == '0) ? S_ADD_SHIFT
                                                               : S_ADD_RD;
                                    r_res <= '{status: stq_pkg::ST_ADDED,
                                               handle: 4'(free_slot),
                                               fired: '0, last: 1'b1};
                                end
                            end
                            stq_pkg::FUNC_CANCEL: begin
                                r_res <= '{status: stq_pkg::ST_NOT_FOUND,
                                           handle: i_cancel_handle,
                                           fired: '0, last: 1'b1};
                                r_pos <= '0;
                                r_state <= S_CAN_SRCH;
                            end
                            stq_pkg::FUNC_TICK: begin
                                r_step  <= r_step + 32'd1;
                                r_fired <= '0;
                                r_state <= S_TICK_CHK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // Wait for the due step read at r_pos.
                S_ADD_RD: r_state <= S_ADD_CMP;
                // The head is checked first, then the tail, then the list from
                // position one onward for the first entry due at or after.
                S_ADD_CMP: begin
                    if (r_tail_chk) begin
                        r_tail_chk <= 1'b0;
                        if (due_le) begin
                            r_pos <= r_count;
                            r_state <= S_ADD_SHIFT;
                        end else begin
                            r_pos <= CW'(1);
                            r_state <= S_ADD_RD;
                        end
                    end else if (due_ge) begin
                        r_state <= S_ADD_SHIFT;
                    end else if (r_pos == '0 && r_count != CW'(1)) begin
                        r_pos <= r_count - CW'(1);
                        r_tail_chk <= 1'b1;
                        r_state <= S_ADD_RD;
                    end else if (r_pos == r_count - CW'(1)) begin
                        r_pos <= r_count;
                        r_state <= S_ADD_SHIFT;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                        r_state <= S_ADD_RD;
                    end
                end
                // Open the gap at r_pos in one parallel shift and drop the slot in.
                S_ADD_SHIFT: begin
                    r_order[pos_idx] <= r_slot;
                    for (int i = 1; i < QUEUE_DEPTH; i++) begin
                        if (CW'(i) > r_pos && CW'(i) <= r_count) begin
                            r_order[i] <= r_order[i-1];
                        end
                    end
                    r_count <= r_count + CW'(1);
                    r_state <= S_PUT;
                end
                S_CAN_SRCH: begin
                    if (r_pos >= r_count) begin
                        r_state <= S_PUT;
                    end else if (4'(r_order[pos_idx]) == r_res.handle) begin
                        r_res.status <= stq_pkg::ST_CANCELLED;
                        r_state <= S_REMOVE;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                end
                S_REMOVE: begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        if (CW'(i) >= r_pos) begin
                            r_order[i] <= r_order[i+1];
                        end
                    end
                    r_count <= r_count - CW'(1);
                    r_state <= r_after_tick ? S_TICK_CHK : S_PUT;
                end
                S_TICK_CHK: begin
                    if (r_count == '0 || r_fired == 5'(stq_pkg::MAX_FIRE)) begin
                        if (r_fired != '0 && out_free) begin
                            r_state <= S_IDLE;
                        end else if (r_fired == '0) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_TICK_RD;
                    end
                end
                S_TICK_RD: r_state <= S_TICK_WAIT;
                S_TICK_WAIT: begin
                    if (due_rd <= r_step) begin
                        r_state <= S_TICK_OUT;
                    end else if (r_fired != '0) begin
                        r_fired <= 5'(stq_pkg::MAX_FIRE);
                        r_state <= S_TICK_CHK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                // Hand the previously held fired word out, then hold this one.
                S_TICK_OUT: begin
                    if (r_fired == '0 || out_free) begin
                        r_res <= '{status: stq_pkg::ST_FIRED, handle: 4'(r_order[0]),
                                   fired: pay_rd, last: 1'b0};
                        r_fired <= r_fired + 5'd1;
                        r_pos <= '0;
                        r_after_tick <= 1'b1;
                        r_state <= S_REMOVE;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_out.status;
    assign o_handle         = r_out.handle;
    assign o_fired_owner    = r_out.fired.owner;
    assign o_fired_callback = r_out.fired.callback;
    assign o_fired_argument = r_out.fired.argument;
    assign o_fired_kind     = r_out.fired.kind;
    assign o_last           = r_out.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepting while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_out)))
        else $error("result lost under stall");
    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fired <= 5'(stq_pkg::MAX_FIRE)) else $error("too many fired");
`endif
endmodule

// ===== verif/sorted_timer_queue_test.sv =====
// Testbench for sorted_timer_queue: directed and random add, cancel and tick
// words checked against a behavioral timer-queue predictor.
// Depends on stq_pkg and the sorted_timer_queue RTL.
`timescale 1ns / 100ps

module sorted_timer_queue_test;

    localparam int DEPTH = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = stq_pkg::FUNC_ADD;
    logic [15:0] i_delay_steps = '0;
    logic [15:0] i_owner_id = '0;
    logic [15:0] i_callback_id = '0;
    logic [31:0] i_argument = '0;
    logic        i_script_kind = 1'b0;
    logic [3:0]  i_cancel_handle = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_handle;
    logic [15:0] o_fired_owner;
    logic [15:0] o_fired_callback;
    logic [31:0] o_fired_argument;
    logic        o_fired_kind;
    logic        o_last;

    sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: our own copy of the timer queue.
    logic [31:0]       step_now;
    logic [31:0]       slot_due [DEPTH];
    stq_pkg::t_payload slot_data [DEPTH];
    logic [3:0]        order_q [$];
    stq_pkg::t_result  pending_results [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;        // disables random idling on both sides
    bit  hold_output = 0;  // long receiver hold-off
    int  hold_cycles = 0;

    // Works out the results that one input word causes and queues them.
    task automatic predict_word(input logic [1:0] func, input logic [15:0] dly,
                                input stq_pkg::t_payload pl, input logic [3:0] hnd);
        stq_pkg::t_result r;
        bit used [DEPTH];
        int slot, pos, n;
        logic [31:0] due;
        r = '0;
        r.last = 1'b1;
        case (func)
            stq_pkg::FUNC_ADD: begin
                if (order_q.size() >= DEPTH) begin
                    r.status = stq_pkg::ST_FULL;
                    pending_results.push_back(r);
                end else begin
                    foreach (used[i]) used[i] = 0;
                    foreach (order_q[i]) used[order_q[i]] = 1;
                    slot = 0;
                    while (used[slot]) slot++;
                    due = step_now + 32'(dly);
                    slot_due[slot] = due;
                    slot_data[slot] = pl;
                    if (order_q.size() == 0 || due <= slot_due[order_q[0]])
                        pos = 0;
                    else if (due >= slot_due[order_q[$]])
                        pos = order_q.size();
                    else begin
                        pos = 1;
                        while (pos < order_q.size() && due > slot_due[order_q[pos]]) pos++;
                    end
                    order_q.insert(pos, 4'(slot));
                    r.status = stq_pkg::ST_ADDED;
                    r.handle = 4'(slot);
                    pending_results.push_back(r);
                end
            end
            stq_pkg::FUNC_CANCEL: begin
                r.status = stq_pkg::ST_NOT_FOUND;
                r.handle = hnd;
                for (int i = 0; i < order_q.size(); i++) begin
                    if (order_q[i] == hnd) begin
                        order_q.delete(i);
                        r.status = stq_pkg::ST_CANCELLED;
                        break;
                    end
                end
                pending_results.push_back(r);
            end
            stq_pkg::FUNC_TICK: begin
                step_now = step_now + 1;
                n = 0;
                while (order_q.size() > 0 && n < stq_pkg::MAX_FIRE &&
                       slot_due[order_q[0]] <= step_now) begin
                    r.status = stq_pkg::ST_FIRED;
                    r.handle = order_q[0];
                    r.fired = slot_data[order_q[0]];
                    r.last = 1'b0;
                    order_q.pop_front();
                    // The final fired timer carries the last flag.
                    if (order_q.size() == 0 || n == stq_pkg::MAX_FIRE - 1 ||
                        slot_due[order_q[0]] > step_now)
                        r.last = 1'b1;
                    pending_results.push_back(r);
                    n++;
                end
            end
            default: ;
        endcase
    endtask

    // Sends one word: drives it at the falling edge, holds it until accepted.
    // Valid stays high into the next word; a caller that pauses drops it.
    task automatic send_word(input logic [1:0] func, input logic [15:0] dly,
                             input stq_pkg::t_payload pl, input logic [3:0] hnd);
        int gap;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < 22) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func <= func;
        i_delay_steps <= dly;
        i_owner_id <= pl.owner;
        i_callback_id <= pl.callback;
        i_argument <= pl.argument;
        i_script_kind <= pl.kind;
        i_cancel_handle <= hnd;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_word(func, dly, pl, hnd);
        @(negedge i_clk);
    endtask

    function automatic stq_pkg::t_payload rand_payload();
        stq_pkg::t_payload p;
        p.owner = 16'($urandom);
        p.callback = 16'($urandom);
        p.argument = $urandom;
        p.kind = 1'($urandom);
        return p;
    endfunction

    task automatic add_timer(input logic [15:0] dly);
        send_word(stq_pkg::FUNC_ADD, dly, rand_payload(), 4'($urandom));
    endtask

    task automatic cancel_timer(input logic [3:0] hnd);
        send_word(stq_pkg::FUNC_CANCEL, 16'($urandom), rand_payload(), hnd);
    endtask

    task automatic tick_step();
        send_word(stq_pkg::FUNC_TICK, 16'($urandom), rand_payload(), 4'($urandom));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Fill to capacity, overflow, ties at the head and mid-list, extreme fields.
    task automatic test_fill_and_full();
        stq_pkg::t_payload p;
        p = '1;
        send_word(stq_pkg::FUNC_ADD, 16'hFFFF, p, 4'hF);
        p = '0;
        send_word(stq_pkg::FUNC_ADD, 16'h0000, p, 4'h0);
        add_timer(16'd5);
        add_timer(16'd5);
        add_timer(16'd0);
        add_timer(16'd3);
        for (int i = 0; i < 10; i++) add_timer(16'($urandom_range(1, 8)));
        add_timer(16'd2);
        add_timer(16'd2);
        drain_results();
    endtask

    // Cancel of queued, free and repeated handles, plus the unused operation.
    task automatic test_cancel_and_unused();
        cancel_timer(4'd3);
        cancel_timer(4'd3);
        cancel_timer(4'd0);
        send_word(FUNC_UNUSED, 16'hFFFF, rand_payload(), 4'hF);
        cancel_timer(4'hF);
        drain_results();
    endtask

    // Ticks until everything with a short delay has fired; sixteen at once too.
    task automatic test_burst_fire();
        for (int i = 0; i < 10; i++) tick_step();
        while (order_q.size() > 0) cancel_timer(order_q[0]);
        tick_step();
        for (int i = 0; i < DEPTH; i++) add_timer(16'd1);
        add_timer(16'd1);
        tick_step();
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        hold_cycles = 600;
        hold_output = 1;
        quiet = 1;
        for (int i = 0; i < 20; i++) begin
            if (i % 4 == 3) tick_step(); else add_timer(16'($urandom_range(0, 3)));
        end
        quiet = 0;
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (hold_output == 0);
        drain_results();
    endtask

    // Random mix, mostly adds and ticks with small delays to keep firing.
    task automatic test_random(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            quiet = (i >= count / 2 && i < count / 2 + 60);
            pick = $urandom_range(99);
            if (pick < 40)
                add_timer(pick < 4 ? 16'($urandom) : 16'($urandom_range(0, 12)));
            else if (pick < 55)
                cancel_timer(order_q.size() > 0 && pick < 50 ?
                             order_q[$urandom_range(order_q.size() - 1)] : 4'($urandom));
            else if (pick < 97)
                tick_step();
            else
                send_word(FUNC_UNUSED, 16'($urandom), rand_payload(), 4'($urandom));
        end
        quiet = 0;
        drain_results();
    endtask

    // Receiver stall: random idling, or a long counted hold-off.
    always @(negedge i_clk) begin
        if (hold_output) begin
            i_stall <= 1'b1;
            if (hold_cycles == 0) hold_output <= 0;
            else hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 22);
        end
    end

    // Result checker: compares each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        stq_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word status=%0d handle=%0d", o_status, o_handle);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_handle !== want.handle) begin
                    $error("handle: expected %0d, got %0d", want.handle, o_handle);
                    error_count++;
                end
                if (o_fired_owner !== want.fired.owner) begin
                    $error("fired_owner: expected %h, got %h", want.fired.owner, o_fired_owner);
                    error_count++;
                end
                if (o_fired_callback !== want.fired.callback) begin
                    $error("fired_callback: expected %h, got %h",
                           want.fired.callback, o_fired_callback);
                    error_count++;
                end
                if (o_fired_argument !== want.fired.argument) begin
                    $error("fired_argument: expected %h, got %h",
                           want.fired.argument, o_fired_argument);
                    error_count++;
                end
                if (o_fired_kind !== want.fired.kind) begin
                    $error("fired_kind: expected %0d, got %0d", want.fired.kind, o_fired_kind);
                    error_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("sorted_timer_queue_test: FAIL");
            $finish;
        end
    end

    initial begin
        step_now = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_fill_and_full();
        test_cancel_and_unused();
        test_burst_fire();
        test_backpressure();
        test_random(340);
        if (error_count == 0 && pending_results.size() == 0)
            $display("sorted_timer_queue_test: PASS");
        else
            $display("sorted_timer_queue_test: FAIL");
        $finish;
    end

endmodule
